@@ src/dplt_pkg.sv @@
// Shared constants, types and width helpers for the two-level page translator.
package dplt_pkg;

   // Default geometry: 10/10/12 split, four table slots, 64 frames.
   localparam int DEF_OFFSET_WIDTH      = 12;
   localparam int DEF_TABLE_INDEX_WIDTH = 10;
   localparam int DEF_DIR_INDEX_WIDTH   = 10;
   localparam int DEF_TABLE_SLOTS       = 4;
   localparam int DEF_FRAME_COUNT       = 64;

   localparam int COUNT_WIDTH     = 32;
   localparam int RSP_FRAME_WIDTH = 6;
   localparam int STATUS_WIDTH    = 2;
   localparam int OP_WIDTH        = 1;

   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam status_type STATUS_HIT      = 2'd0;
   localparam status_type STATUS_MISS     = 2'd1;
   localparam status_type STATUS_NO_SLOT  = 2'd2;
   localparam status_type STATUS_NO_FRAME = 2'd3;

   localparam logic [OP_WIDTH-1:0] OP_LOAD  = 1'b0;
   localparam logic [OP_WIDTH-1:0] OP_STORE = 1'b1;

   // Read and write strobes for the directory and table memories.
   typedef struct packed {
      logic dir_rd;
      logic tbl_rd;
      logic dir_wr;
      logic tbl_wr;
   } pt_ctl_type;

   // Bits needed to index n entries (at least one).
   function automatic int idx_width(input int n);
      idx_width = (n <= 1) ? 1 : $clog2(n);
   endfunction

   // Bits needed to hold the values 0..n.
   function automatic int cnt_width(input int n);
      cnt_width = $clog2(n + 1);
   endfunction

   // Saturating increment of an event counter.
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
   endfunction

endpackage

@@ src/demand_paged_two_level_translator.sv @@
// Top level: demand-paged two-level address translator with byte frames.
//
//  channel   ports                          accepted when
//  --------  -----------------------------  ------------------------------
//  request   start, busy, req_*             start high and busy low
//  result    rsp_valid, rsp_*               rsp_valid high (one cycle)
//
// For each item the directory read, the dependent table read and the
// frame byte access are chained memory reads. The result shows
// in the cycle after the table stage, and busy is low in that cycle, so the
// next item is taken while the result is on the ports.
// After reset the block clears the directory and table valid bits, one entry
// of each a cycle; busy stays high until the clearing pass is done.
// The receiver cannot stall; nothing waits on it.
module demand_paged_two_level_translator import dplt_pkg::*; #(
   parameter int OFFSET_WIDTH      = DEF_OFFSET_WIDTH,
   parameter int TABLE_INDEX_WIDTH = DEF_TABLE_INDEX_WIDTH,
   parameter int DIR_INDEX_WIDTH   = DEF_DIR_INDEX_WIDTH,
   parameter int TABLE_SLOTS       = DEF_TABLE_SLOTS,
   parameter int FRAME_COUNT       = DEF_FRAME_COUNT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_op,
   input  logic [31:0]                req_virt_addr,
   input  logic [7:0]                 req_store_byte,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_load_byte,
   output logic [STATUS_WIDTH-1:0]    rsp_status,
   output logic                       rsp_new_table,
   output logic                       rsp_new_frame,
   output logic [RSP_FRAME_WIDTH-1:0] rsp_frame_number,
   output logic [COUNT_WIDTH-1:0]     rsp_hits,
   output logic [COUNT_WIDTH-1:0]     rsp_misses,
   output logic [COUNT_WIDTH-1:0]     rsp_faults
);

   localparam int SLOT_W  = idx_width(TABLE_SLOTS);
   localparam int FRAME_W = idx_width(FRAME_COUNT);
   localparam int NS_W    = cnt_width(TABLE_SLOTS);
   localparam int NF_W    = cnt_width(FRAME_COUNT);
   localparam int TBL_AW  = SLOT_W + TABLE_INDEX_WIDTH;
   localparam int SPLIT_W = OFFSET_WIDTH + TABLE_INDEX_WIDTH + DIR_INDEX_WIDTH;
   localparam int VA_W    = (SPLIT_W > 32) ? SPLIT_W : 32;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_DIR   = 4'b0100,
      ST_TBL   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Address split; bits above the 32-bit request address read as zero.
   logic [VA_W-1:0]              va_ext;
   logic [DIR_INDEX_WIDTH-1:0]   req_di;
   logic                         accept;

   // Item held through the walk.
   logic                         op_ff;
   logic [7:0]                   store_byte_ff;
   logic [OFFSET_WIDTH-1:0]      off_ff;
   logic [TABLE_INDEX_WIDTH-1:0] ti_ff;
   logic [DIR_INDEX_WIDTH-1:0]   di_ff;

   // Allocation pointers and counters.
   logic [NS_W-1:0]        next_slot_ff, next_slot_in;
   logic [NF_W-1:0]        next_frame_ff, next_frame_in;
   logic [COUNT_WIDTH-1:0] hits_ff, hits_in;
   logic [COUNT_WIDTH-1:0] misses_ff, misses_in;
   logic [COUNT_WIDTH-1:0] faults_ff, faults_in;

   // Result registers.
   logic                       rsp_valid_ff;
   logic                       load_sel_ff;
   status_type                 status_ff;
   logic                       new_table_ff;
   logic                       new_frame_ff;
   logic [RSP_FRAME_WIDTH-1:0] frame_number_ff;

   // Memory interfaces.
   pt_ctl_type          pt_ctl;
   logic                dir_valid, tbl_valid, clear_done;
   logic [SLOT_W-1:0]   dir_slot;
   logic [FRAME_W-1:0]  tbl_frame;
   logic [TBL_AW-1:0]   tbl_rd_addr, tbl_wr_addr;
   logic                fs_wr, fs_rd;
   logic [7:0]          fs_rdata;

   // Table-stage decision.
   logic               in_tbl;
   logic               have_frm, no_slot, no_frame, alloc, ok;
   logic [SLOT_W-1:0]  slot_use;
   logic [FRAME_W-1:0] frame_use;
   status_type         status_calc;

   assign va_ext = VA_W'(req_virt_addr);
   assign req_di = va_ext[OFFSET_WIDTH + TABLE_INDEX_WIDTH +: DIR_INDEX_WIDTH];
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign in_tbl = (state_ff == ST_TBL);

   // Sequencer: the dir read is issued on the accept edge, the table read in
   // the dir stage, and all writes plus the frame access in the table stage.
   // Writes land before the next accept can read, so no forwarding is needed.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (start)      state_in = ST_DIR;
         ST_DIR:                   state_in = ST_TBL;
         ST_TBL:                   state_in = ST_IDLE;
         default:                  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= in_tbl;
      end
   end

   // Capture the item on accept.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         store_byte_ff <= req_store_byte;
         off_ff        <= va_ext[OFFSET_WIDTH-1:0];
         ti_ff         <= va_ext[OFFSET_WIDTH +: TABLE_INDEX_WIDTH];
         di_ff         <= req_di;
      end
   end

   // Decide hit, allocation or error from the two memory words.
   always_comb begin
      have_frm  = dir_valid && tbl_valid;
      no_slot   = !dir_valid && (next_slot_ff == NS_W'(TABLE_SLOTS));
      no_frame  = !have_frm && !no_slot && (next_frame_ff == NF_W'(FRAME_COUNT));
      alloc     = !have_frm && !no_slot && !no_frame;
      ok        = have_frm || alloc;
      slot_use  = dir_valid ? dir_slot : next_slot_ff[SLOT_W-1:0];
      frame_use = have_frm ? tbl_frame : next_frame_ff[FRAME_W-1:0];
      if (have_frm) begin
         status_calc = STATUS_HIT;
      end else if (no_slot) begin
         status_calc = STATUS_NO_SLOT;
      end else if (no_frame) begin
         status_calc = STATUS_NO_FRAME;
      end else begin
         status_calc = STATUS_MISS;
      end
   end

   assign tbl_rd_addr = {dir_slot, ti_ff};
   assign tbl_wr_addr = {slot_use, ti_ff};

   always_comb begin
      pt_ctl.dir_rd = accept;
      pt_ctl.tbl_rd = (state_ff == ST_DIR);
      pt_ctl.dir_wr = in_tbl && alloc && !dir_valid;
      pt_ctl.tbl_wr = in_tbl && alloc;
   end

   assign fs_wr = in_tbl && ok && (op_ff == OP_STORE);
   assign fs_rd = in_tbl && ok && (op_ff == OP_LOAD);

   // Advance pointers and counters in the table stage.
   always_comb begin
      next_slot_in  = next_slot_ff;
      next_frame_in = next_frame_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      faults_in     = faults_ff;
      if (in_tbl) begin
         if (pt_ctl.dir_wr) next_slot_in = next_slot_ff + NS_W'(1);
         if (alloc)         next_frame_in = next_frame_ff + NF_W'(1);
         if (ok)            hits_in = sat_inc(hits_ff);
         if (!have_frm) begin
            misses_in = sat_inc(misses_ff);
            faults_in = sat_inc(faults_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff  <= '0;
         next_frame_ff <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         faults_ff     <= '0;
      end else begin
         next_slot_ff  <= next_slot_in;
         next_frame_ff <= next_frame_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         faults_ff     <= faults_in;
      end
   end

   // Hold the result fields for the strobe cycle.
   always_ff @(posedge clock) begin
      if (in_tbl) begin
         load_sel_ff     <= ok && (op_ff == OP_LOAD);
         status_ff       <= status_calc;
         new_table_ff    <= pt_ctl.dir_wr;
         new_frame_ff    <= alloc;
         frame_number_ff <= ok ? RSP_FRAME_WIDTH'(frame_use) : '0;
      end
   end

   dplt_page_tables #(
      .TABLE_INDEX_WIDTH (TABLE_INDEX_WIDTH),
      .DIR_INDEX_WIDTH   (DIR_INDEX_WIDTH),
      .TABLE_SLOTS       (TABLE_SLOTS),
      .FRAME_COUNT       (FRAME_COUNT)
   ) u_tables (
      .clock        (clock),
      .reset        (reset),
      .ctl          (pt_ctl),
      .dir_rd_addr  (req_di),
      .dir_wr_addr  (di_ff),
      .dir_wr_slot  (slot_use),
      .tbl_rd_addr  (tbl_rd_addr),
      .tbl_wr_addr  (tbl_wr_addr),
      .tbl_wr_frame (frame_use),
      .dir_valid    (dir_valid),
      .dir_slot     (dir_slot),
      .tbl_valid    (tbl_valid),
      .tbl_frame    (tbl_frame),
      .clear_done   (clear_done)
   );

   dplt_frame_store #(
      .OFFSET_WIDTH (OFFSET_WIDTH),
      .FRAME_COUNT  (FRAME_COUNT)
   ) u_frames (
      .clock   (clock),
      .wr_en   (fs_wr),
      .rd_en   (fs_rd),
      .addr    ({frame_use, off_ff}),
      .wr_data (store_byte_ff),
      .rd_data (fs_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_load_byte    = load_sel_ff ? fs_rdata : 8'd0;
   assign rsp_status       = status_ff;
   assign rsp_new_table    = new_table_ff;
   assign rsp_new_frame    = new_frame_ff;
   assign rsp_frame_number = frame_number_ff;
   assign rsp_hits         = hits_ff;
   assign rsp_misses       = misses_ff;
   assign rsp_faults       = faults_ff;

   // A result only follows the table stage.
   a_rsp_after_tbl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_TBL))
      else $error("result strobe without a table stage");

   // A new table slot always comes with a new frame.
   a_table_implies_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && new_table_ff |-> new_frame_ff)
      else $error("table slot allocated without a frame");

   // Errors allocate nothing and report frame zero.
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_NO_SLOT || status_ff == STATUS_NO_FRAME)
      |-> !new_table_ff && !new_frame_ff && (frame_number_ff == '0))
      else $error("error result with allocation or frame");

   // Pointers never pass their pool size.
   a_pointer_bound: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= NS_W'(TABLE_SLOTS) && next_frame_ff <= NF_W'(FRAME_COUNT))
      else $error("allocation pointer past pool");

   // Hit counter never goes backward.
   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> hits_ff >= $past(hits_ff))
      else $error("hit counter decreased");

endmodule

@@ src/dplt_page_tables.sv @@
// Directory and page table memories with the clearing pass after reset.
module dplt_page_tables import dplt_pkg::*; #(
   parameter int TABLE_INDEX_WIDTH = DEF_TABLE_INDEX_WIDTH,
   parameter int DIR_INDEX_WIDTH   = DEF_DIR_INDEX_WIDTH,
   parameter int TABLE_SLOTS       = DEF_TABLE_SLOTS,
   parameter int FRAME_COUNT       = DEF_FRAME_COUNT,
   localparam int SLOT_W           = idx_width(TABLE_SLOTS),
   localparam int FRAME_W          = idx_width(FRAME_COUNT),
   localparam int TBL_AW           = SLOT_W + TABLE_INDEX_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pt_ctl_type                 ctl,
   input  logic [DIR_INDEX_WIDTH-1:0] dir_rd_addr,
   input  logic [DIR_INDEX_WIDTH-1:0] dir_wr_addr,
   input  logic [SLOT_W-1:0]          dir_wr_slot,
   input  logic [TBL_AW-1:0]          tbl_rd_addr,
   input  logic [TBL_AW-1:0]          tbl_wr_addr,
   input  logic [FRAME_W-1:0]         tbl_wr_frame,
   output logic                       dir_valid,
   output logic [SLOT_W-1:0]          dir_slot,
   output logic                       tbl_valid,
   output logic [FRAME_W-1:0]         tbl_frame,
   output logic                       clear_done
);

   localparam int DIR_DEPTH = 1 << DIR_INDEX_WIDTH;
   localparam int TBL_DEPTH = TABLE_SLOTS * (1 << TABLE_INDEX_WIDTH);
   localparam int CLR_DEPTH = (DIR_DEPTH > TBL_DEPTH) ? DIR_DEPTH : TBL_DEPTH;
   localparam int CLR_W     = (DIR_INDEX_WIDTH > TBL_AW) ? DIR_INDEX_WIDTH : TBL_AW;

   logic [SLOT_W:0]  dir_mem [DIR_DEPTH];
   logic [FRAME_W:0] tbl_mem [TBL_DEPTH];

   logic [SLOT_W:0]  dir_rdata_ff;
   logic [FRAME_W:0] tbl_rdata_ff;

   logic             clearing_ff, clearing_in;
   logic [CLR_W-1:0] clr_ff, clr_in;

   logic                       dir_we, tbl_we;
   logic [DIR_INDEX_WIDTH-1:0] dir_waddr;
   logic [TBL_AW-1:0]          tbl_waddr;
   logic [SLOT_W:0]            dir_wdata;
   logic [FRAME_W:0]           tbl_wdata;

   // Sweep both memories once, writing invalid entries.
   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + CLR_W'(1);
         if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   always_comb begin
      if (clearing_ff) begin
         dir_we    = ({1'b0, clr_ff} < (CLR_W + 1)'(DIR_DEPTH));
         tbl_we    = ({1'b0, clr_ff} < (CLR_W + 1)'(TBL_DEPTH));
         dir_waddr = clr_ff[DIR_INDEX_WIDTH-1:0];
         tbl_waddr = clr_ff[TBL_AW-1:0];
         dir_wdata = '0;
         tbl_wdata = '0;
      end else begin
         dir_we    = ctl.dir_wr;
         tbl_we    = ctl.tbl_wr;
         dir_waddr = dir_wr_addr;
         tbl_waddr = tbl_wr_addr;
         dir_wdata = {1'b1, dir_wr_slot};
         tbl_wdata = {1'b1, tbl_wr_frame};
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      if (ctl.dir_rd) begin
         dir_rdata_ff <= dir_mem[dir_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (ctl.tbl_rd) begin
         tbl_rdata_ff <= tbl_mem[tbl_rd_addr];
      end
   end

   assign dir_valid  = dir_rdata_ff[SLOT_W];
   assign dir_slot   = dir_rdata_ff[SLOT_W-1:0];
   assign tbl_valid  = tbl_rdata_ff[FRAME_W];
   assign tbl_frame  = tbl_rdata_ff[FRAME_W-1:0];
   assign clear_done = !clearing_ff;

endmodule

@@ src/dplt_frame_store.sv @@
// Byte-addressed page frame memory with a registered read port.
module dplt_frame_store import dplt_pkg::*; #(
   parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH,
   parameter int FRAME_COUNT  = DEF_FRAME_COUNT,
   localparam int FRAME_W     = idx_width(FRAME_COUNT),
   localparam int ADDR_W      = FRAME_W + OFFSET_WIDTH
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wr_data,
   output logic [7:0]        rd_data
);

   localparam int DEPTH = FRAME_COUNT * (1 << OFFSET_WIDTH);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
